### rtl/core/ssfs_pkg.sv
package ssfs_pkg;

    localparam int NUMBER_W = 14;
    localparam int LEVEL_W  = 4;
    localparam int KIND_W   = 2;
    localparam int BYTE_W   = 8;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [3:0]        t_digit;

    typedef enum logic {
        OP_SHOW   = 1'b0,
        OP_BRIGHT = 1'b1
    } t_operation;

    typedef enum logic [KIND_W-1:0] {
        EV_START = 2'd0,
        EV_WRITE = 2'd1,
        EV_ACK   = 2'd2,
        EV_STOP  = 2'd3
    } t_event_kind;

    localparam t_byte CMD_DATA   = 8'h40;
    localparam t_byte CMD_ADDR   = 8'hc0;
    localparam t_byte CMD_BRIGHT = 8'h87;
    localparam t_byte COLON_BIT  = 8'h80;
    localparam logic [LEVEL_W-1:0] BRIGHT_MAX = 4'd8;

    // number / 100 as (number * 5243) >> 19, exact for number below 16384
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;
    // x / 10 as (x * 205) >> 11, exact for x below 100
    localparam int DIV10_MUL    = 205;
    localparam int DIV10_SHIFT  = 11;

    // Last event of each frame
    localparam logic [3:0] SHOW_LAST   = 4'd15;
    localparam logic [3:0] BRIGHT_LAST = 4'd3;

    function automatic t_byte seg_encode(input logic flip, input t_digit d);
        t_byte seg;
        seg = 8'h00;
        if (!flip) begin
            case (d)
                4'd0:    seg = 8'h3f;
                4'd1:    seg = 8'h06;
                4'd2:    seg = 8'h5b;
                4'd3:    seg = 8'h4f;
                4'd4:    seg = 8'h66;
                4'd5:    seg = 8'h6d;
                4'd6:    seg = 8'h7d;
                4'd7:    seg = 8'h07;
                4'd8:    seg = 8'h7f;
                4'd9:    seg = 8'h6f;
                default: seg = 8'h00;
            endcase
        end else begin
            case (d)
                4'd0:    seg = 8'h3f;
                4'd1:    seg = 8'h30;
                4'd2:    seg = 8'h5b;
                4'd3:    seg = 8'h79;
                4'd4:    seg = 8'h74;
                4'd5:    seg = 8'h6d;
                4'd6:    seg = 8'h6f;
                4'd7:    seg = 8'h38;
                4'd8:    seg = 8'h7f;
                4'd9:    seg = 8'h7d;
                default: seg = 8'h00;
            endcase
        end
        return seg;
    endfunction

endpackage

### rtl/core/ssfs_req_if.sv
interface ssfs_req_if;
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [ssfs_pkg::NUMBER_W-1:0] number;
    logic                          colon;
    logic [ssfs_pkg::LEVEL_W-1:0]  brightness;

    modport source (output valid, operation, number, colon, brightness, input ready);
    modport sink   (input valid, operation, number, colon, brightness, output ready);
endinterface

### rtl/core/ssfs_evt_if.sv
interface ssfs_evt_if;
    logic                        valid;
    logic                        ready;
    logic [ssfs_pkg::KIND_W-1:0] event_kind;
    logic [ssfs_pkg::BYTE_W-1:0] data_byte;
    logic                        last;

    modport source (output valid, event_kind, data_byte, last, input ready);
    modport sink   (input valid, event_kind, data_byte, last, output ready);
endinterface

### rtl/core/seven_segment_serial_frame_sender.sv
// Frame sequencer for a four-digit seven-segment display on a two-wire bus.
//
// i_req carries one request: show a number (0..9999, optional colon) or set
// the brightness (0..8, higher levels clamp to 8). o_evt carries the bus
// events for the physical layer: start, write byte, ack clock, stop, with
// last marking the final event of a frame.
// A show request gives 16 events, a brightness request gives 4.
// i_cfg_we / i_cfg_wdata write flip_over (mirrored segment map, ones digit
// first); write it only while no request is in flight.
//
// The first event of a request passes through four split stages, the frame
// sequencer and the output register before it is valid on o_evt.
// Throughput: one event per cycle while o_evt.ready stays high; the event
// counter of the sequencer steps through the events of each frame.
// The split stages keep taking requests while a frame is still being sent,
// and the next frame follows the previous one without a gap.
//
// Reset (synchronous, active low) empties every stage and clears flip_over.
// When the receiver holds o_evt.ready low the output event holds, the
// sequencer waits and the stages behind it fill up before i_req.ready drops.
module seven_segment_serial_frame_sender (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    ssfs_req_if.sink   i_req,
    ssfs_evt_if.source o_evt
);
    import ssfs_pkg::*;

    // Configuration
    logic r_flip_over;

    // Stage 1: captured request
    logic                r_s1_valid;
    t_operation          r_s1_op;
    logic [NUMBER_W-1:0] r_s1_number;
    logic                r_s1_colon;
    t_byte               r_s1_bright;

    // Stage 2: hundreds quotient
    logic                r_s2_valid;
    t_operation          r_s2_op;
    logic [NUMBER_W-1:0] r_s2_number;
    logic [7:0]          r_s2_q;
    logic                r_s2_colon;
    t_byte               r_s2_bright;

    // Stage 3: low and high pairs of digits
    logic       r_s3_valid;
    t_operation r_s3_op;
    logic [6:0] r_s3_lo;
    logic [6:0] r_s3_hi;
    logic       r_s3_colon;
    t_byte      r_s3_bright;

    // Stage 4: tens of each pair
    logic       r_s4_valid;
    t_operation r_s4_op;
    logic [6:0] r_s4_lo;
    logic [6:0] r_s4_hi;
    t_digit     r_s4_tens_lo;
    t_digit     r_s4_tens_hi;
    logic       r_s4_colon;
    t_byte      r_s4_bright;

    // Frame sequencer
    logic       r_seq_valid;
    t_operation r_seq_op;
    t_byte      r_seq_byte [4];
    logic [3:0] r_seq_cnt;

    // Output register
    logic        r_out_valid;
    t_event_kind r_out_kind;
    t_byte       r_out_byte;
    logic        r_out_last;

    logic out_free, seq_emit, seq_last, seq_free;
    logic s4_free, s3_free, s2_free, s1_free;

    logic [LEVEL_W-1:0] in_level;
    logic [26:0]        q_prod;
    logic [13:0]        hund;
    logic [13:0]        rem;
    logic [7:0]         hi_pair;
    logic [14:0]        tens_lo_prod, tens_hi_prod;
    logic [6:0]         ones_lo_w, ones_hi_w;
    t_digit             digit [4];
    t_byte              seg [4];
    t_byte              n_seq_byte [4];
    t_event_kind        n_out_kind;
    t_byte              n_out_byte;

    // Handshake chain: a stage takes new data when it is empty or moving on
    assign out_free = !r_out_valid || o_evt.ready;
    assign seq_emit = r_seq_valid && out_free;
    assign seq_last = (r_seq_op == OP_BRIGHT) ? (r_seq_cnt == BRIGHT_LAST)
                                              : (r_seq_cnt == SHOW_LAST);
    assign seq_free = !r_seq_valid || (seq_emit && seq_last);
    assign s4_free  = !r_s4_valid || seq_free;
    assign s3_free  = !r_s3_valid || s4_free;
    assign s2_free  = !r_s2_valid || s3_free;
    assign s1_free  = !r_s1_valid || s2_free;

    assign i_req.ready = s1_free;

    // Clamp the level so the command byte tops out at 0x8f
    assign in_level = (i_req.brightness > BRIGHT_MAX) ? BRIGHT_MAX : i_req.brightness;

    // Stage 1 to 2: number / 100 by reciprocal
    assign q_prod = 27'(r_s1_number) * 27'(DIV100_MUL);

    // Stage 2 to 3: low pair is the remainder, high pair is the quotient mod 100
    assign hund    = 14'(r_s2_q) * 14'd100;
    assign rem     = r_s2_number - hund;
    assign hi_pair = (r_s2_q >= 8'd100) ? (r_s2_q - 8'd100) : r_s2_q;

    // Stage 3 to 4: tens of each pair
    assign tens_lo_prod = 15'(r_s3_lo) * 15'(DIV10_MUL);
    assign tens_hi_prod = 15'(r_s3_hi) * 15'(DIV10_MUL);

    // Stage 4 to sequencer: ones, segment map, colon and send order
    assign ones_lo_w = r_s4_lo - 7'(r_s4_tens_lo) * 7'd10;
    assign ones_hi_w = r_s4_hi - 7'(r_s4_tens_hi) * 7'd10;
    assign digit[0]  = ones_lo_w[3:0];
    assign digit[1]  = r_s4_tens_lo;
    assign digit[2]  = ones_hi_w[3:0];
    assign digit[3]  = r_s4_tens_hi;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            seg[i] = seg_encode(r_flip_over, digit[i]);
        end
        if (r_s4_colon) begin
            seg[2] = seg[2] | COLON_BIT;
        end
        for (int i = 0; i < 4; i++) begin
            n_seq_byte[i] = r_flip_over ? seg[i] : seg[3-i];
        end
        // Brightness frames carry their command in the first byte slot
        if (r_s4_op == OP_BRIGHT) begin
            n_seq_byte[0] = r_s4_bright;
        end
    end

    // Event for the current sequencer position
    always_comb begin
        n_out_kind = EV_STOP;
        n_out_byte = 8'h00;
        case (r_seq_cnt)
            4'd0, 4'd4: begin
                n_out_kind = EV_START;
            end
            4'd1: begin
                n_out_kind = EV_WRITE;
                n_out_byte = (r_seq_op == OP_BRIGHT) ? r_seq_byte[0] : CMD_DATA;
            end
            4'd5: begin
                n_out_kind = EV_WRITE;
                n_out_byte = CMD_ADDR;
            end
            4'd7: begin
                n_out_kind = EV_WRITE;
                n_out_byte = r_seq_byte[0];
            end
            4'd9: begin
                n_out_kind = EV_WRITE;
                n_out_byte = r_seq_byte[1];
            end
            4'd11: begin
                n_out_kind = EV_WRITE;
                n_out_byte = r_seq_byte[2];
            end
            4'd13: begin
                n_out_kind = EV_WRITE;
                n_out_byte = r_seq_byte[3];
            end
            4'd2, 4'd6, 4'd8, 4'd10, 4'd12, 4'd14: begin
                n_out_kind = EV_ACK;
            end
            4'd3, 4'd15: begin
                n_out_kind = EV_STOP;
            end
            default: begin
                n_out_kind = EV_STOP;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flip_over <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_seq_valid <= 1'b0;
            r_seq_cnt   <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_flip_over <= i_cfg_wdata;
            end
            if (s1_free) r_s1_valid <= i_req.valid;
            if (s2_free) r_s2_valid <= r_s1_valid;
            if (s3_free) r_s3_valid <= r_s2_valid;
            if (s4_free) r_s4_valid <= r_s3_valid;
            // Load the next frame on the last event or when empty, else advance one event
            if (seq_free) begin
                r_seq_valid <= r_s4_valid;
                r_seq_cnt   <= 4'd0;
            end else if (seq_emit) begin
                r_seq_cnt <= r_seq_cnt + 4'd1;
            end
            if (out_free) r_out_valid <= r_seq_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (s1_free) begin
            r_s1_op     <= t_operation'(i_req.operation);
            r_s1_number <= i_req.number;
            r_s1_colon  <= i_req.colon;
            r_s1_bright <= CMD_BRIGHT + t_byte'(in_level);
        end
        if (s2_free) begin
            r_s2_op     <= r_s1_op;
            r_s2_number <= r_s1_number;
            r_s2_q      <= q_prod[DIV100_SHIFT +: 8];
            r_s2_colon  <= r_s1_colon;
            r_s2_bright <= r_s1_bright;
        end
        if (s3_free) begin
            r_s3_op     <= r_s2_op;
            r_s3_lo     <= rem[6:0];
            r_s3_hi     <= hi_pair[6:0];
            r_s3_colon  <= r_s2_colon;
            r_s3_bright <= r_s2_bright;
        end
        if (s4_free) begin
            r_s4_op      <= r_s3_op;
            r_s4_lo      <= r_s3_lo;
            r_s4_hi      <= r_s3_hi;
            r_s4_tens_lo <= tens_lo_prod[DIV10_SHIFT +: 4];
            r_s4_tens_hi <= tens_hi_prod[DIV10_SHIFT +: 4];
            r_s4_colon   <= r_s3_colon;
            r_s4_bright  <= r_s3_bright;
        end
        if (seq_free) begin
            r_seq_op <= r_s4_op;
            for (int i = 0; i < 4; i++) begin
                r_seq_byte[i] <= n_seq_byte[i];
            end
        end
        if (out_free) begin
            r_out_kind <= n_out_kind;
            r_out_byte <= n_out_byte;
            r_out_last <= seq_last;
        end
    end

    assign o_evt.valid      = r_out_valid;
    assign o_evt.event_kind = r_out_kind;
    assign o_evt.data_byte  = r_out_byte;
    assign o_evt.last       = r_out_last;

    // Brightness frames stop after four events
    a_bright_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq_valid && (r_seq_op == OP_BRIGHT) |-> r_seq_cnt <= BRIGHT_LAST)
        else $error("brightness frame overran");

    // Every frame closes with a stop
    a_last_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_evt.valid && o_evt.last |-> o_evt.event_kind == EV_STOP)
        else $error("frame ended on an event other than stop");

    // Only write events carry a byte
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_evt.valid && (o_evt.event_kind != EV_WRITE) |-> o_evt.data_byte == 8'h00)
        else $error("non-write event carries data");

    // Digit split stays decimal
    a_tens_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_valid && (r_s4_op == OP_SHOW) |-> (r_s4_tens_lo <= 4'd9) && (r_s4_tens_hi <= 4'd9))
        else $error("tens digit out of range");

    // An event taken mid-frame moves the sequencer on by one
    a_seq_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_emit && !seq_last |=> r_seq_cnt == $past(r_seq_cnt) + 4'd1)
        else $error("sequencer skipped or repeated an event");

endmodule
